// ----- design/htcw_pkg.sv -----
// shared constants and types for the hit-time coincidence window
`default_nettype none

package htcw_pkg;

  localparam int SLOTS         = 4;
  localparam int FRACTION_BITS = 6;

  // field widths
  localparam int TimeW    = 20;
  localparam int ChannelW = 2;

  // wrap range of the time base: 10240 ns in fixed point
  localparam int Range = (5 * 2048) << FRACTION_BITS;

  // width that holds b + Range - a for a, b below Range
  localparam int DiffW = $clog2(Range) + 1;

  // slot index width, at least one bit; two bits for the four slots
  localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef logic [SLOTS-1:0][TimeW-1:0] slot_times_t;

  typedef struct packed {
    logic [SLOTS-1:0] slot_full;
    logic             win_set;
    logic [TimeW-1:0] win_start;
    logic [TimeW-1:0] win_end;
  } win_state_t;

  typedef struct packed {
    logic             accepted;
    logic             window_valid;
    logic [TimeW-1:0] window_start;
    logic [TimeW-1:0] window_end;
    logic             slot_filled;
    logic [TimeW-1:0] slot_time;
  } result_t;

endpackage

`default_nettype wire

// ----- design/htcw_update.sv -----
// next-state and result logic for one beat
`default_nettype none

module htcw_update (
  input  wire htcw_pkg::win_state_t                state,
  input  wire htcw_pkg::slot_times_t               slot_times,
  input  wire logic [htcw_pkg::TimeW-1:0]          window_width,
  input  wire logic                                cmd,
  input  wire logic [htcw_pkg::ChannelW-1:0]       channel,
  input  wire logic [htcw_pkg::TimeW-1:0]          hit_time,
  output htcw_pkg::win_state_t                     state_next,
  output htcw_pkg::slot_times_t                    slot_times_next,
  output htcw_pkg::result_t                        result
);

  logic [3:0]                      ch_ext;
  logic [htcw_pkg::SlotIdxW-1:0]   idx;
  logic                            ch_ok;
  logic                            t_ok;
  logic                            acc;
  logic [htcw_pkg::DiffW-1:0]      t_ext;
  logic [htcw_pkg::DiffW-1:0]      start_ext;
  logic [htcw_pkg::DiffW-1:0]      end_ext;
  logic [htcw_pkg::DiffW-1:0]      width_ext;
  logic [htcw_pkg::DiffW-1:0]      range_c;
  logic [htcw_pkg::DiffW-1:0]      d1_raw;
  logic [htcw_pkg::DiffW-1:0]      d2_raw;
  logic [htcw_pkg::DiffW-1:0]      d1;
  logic [htcw_pkg::DiffW-1:0]      d2;

  assign ch_ext    = 4'(channel);
  assign idx       = ch_ext[htcw_pkg::SlotIdxW-1:0];
  assign ch_ok     = 5'(channel) < 5'(htcw_pkg::SLOTS);
  assign range_c   = htcw_pkg::DiffW'(htcw_pkg::Range);
  assign t_ext     = htcw_pkg::DiffW'(hit_time);
  assign start_ext = htcw_pkg::DiffW'(state.win_start);
  assign end_ext   = htcw_pkg::DiffW'(state.win_end);
  assign width_ext = htcw_pkg::DiffW'(window_width);
  assign t_ok      = t_ext < range_c;

  // modular distances start -> t and t -> end
  assign d1_raw = t_ext + range_c - start_ext;
  assign d2_raw = end_ext + range_c - t_ext;
  assign d1     = (d1_raw >= range_c) ? d1_raw - range_c : d1_raw;
  assign d2     = (d2_raw >= range_c) ? d2_raw - range_c : d2_raw;

  always_comb begin
    state_next      = state;
    slot_times_next = slot_times;
    acc             = 1'b0;
    if (cmd == htcw_pkg::CMD_CLEAR) begin
      state_next.slot_full = '0;
      state_next.win_set   = 1'b0;
      state_next.win_start = '0;
      state_next.win_end   = '0;
    end else if (ch_ok && t_ok && !state.slot_full[idx]) begin
      if (!state.win_set) begin
        state_next.win_set   = 1'b1;
        state_next.win_start = hit_time;
        state_next.win_end   = hit_time;
        acc                  = 1'b1;
      end else if (d1 < width_ext) begin
        if (d2 != '0) begin
          state_next.win_end = hit_time;
        end
        acc = 1'b1;
      end else if (d2 < width_ext) begin
        if (d1 != '0) begin
          state_next.win_start = hit_time;
        end
        acc = 1'b1;
      end
      if (acc) begin
        slot_times_next[idx]      = hit_time;
        state_next.slot_full[idx] = 1'b1;
      end
    end
  end

  always_comb begin
    result.accepted     = acc;
    result.window_valid = state_next.win_set;
    result.window_start = state_next.win_set ? state_next.win_start : '0;
    result.window_end   = state_next.win_set ? state_next.win_end : '0;
    if (cmd == htcw_pkg::CMD_STORE && ch_ok && state_next.slot_full[idx]) begin
      result.slot_filled = 1'b1;
      result.slot_time   = slot_times_next[idx];
    end else begin
      result.slot_filled = 1'b0;
      result.slot_time   = '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/hit_time_coincidence_window_core.sv -----
// top level: hit-time coincidence window with stream ports and result register
`default_nettype none
// a result beat appears in the cycle after its input beat is taken
// throughput: one beat per cycle while the result register is empty or drains;
//   the slot and window update is combinational up to the result register
// a result waiting in the output register does not block input while m_axis_tready is high
// reset (rst, synchronous): slots empty, window dropped, width zero, no result pending

module hit_time_coincidence_window_core (
  input  wire logic        clk,
  input  wire logic        rst,

  // configuration: coincidence width
  input  wire logic        window_width_we,
  input  wire logic [19:0] window_width_wdata,

  // input beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // hit_time[19:0], zero pad[23:20]
  input  wire logic [2:0]  s_axis_tuser,   // cmd[0], channel[2:1]

  // result beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // accepted[0], window_valid[1],
                                           // window_start[21:2], window_end[41:22],
                                           // slot_filled[42], slot_time[62:43], pad[63]
);

  // slot and window state
  htcw_pkg::win_state_t            state;
  htcw_pkg::win_state_t            state_next;
  htcw_pkg::slot_times_t           slot_times;
  htcw_pkg::slot_times_t           slot_times_next;
  logic [htcw_pkg::TimeW-1:0]      window_width;

  htcw_pkg::result_t               result_next;
  htcw_pkg::result_t               result;
  logic                            in_beat;

  // take a beat whenever the result register is empty or drains this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  htcw_update u_update (
    .state           (state),
    .slot_times      (slot_times),
    .window_width    (window_width),
    .cmd             (s_axis_tuser[0]),
    .channel         (s_axis_tuser[2:1]),
    .hit_time        (s_axis_tdata[19:0]),
    .state_next      (state_next),
    .slot_times_next (slot_times_next),
    .result          (result_next)
  );

  // config register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= '0;
    end else if (window_width_we) begin
      window_width <= window_width_wdata;
    end
  end

  // window state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_beat) begin
        state <= state_next;
      end
      if (in_beat) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed; a slot is only read once it is full
  always_ff @(posedge clk) begin
    if (in_beat) begin
      slot_times <= slot_times_next;
      result     <= result_next;
    end
  end

  assign m_axis_tdata = {1'b0,
                         result.slot_time,
                         result.slot_filled,
                         result.window_end,
                         result.window_start,
                         result.window_valid,
                         result.accepted};

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the hit-time coincidence window core: directed and random beats against a predictor
module tb_top;
  import htcw_pkg::*;

  // watchdog: cycles with no beat on either side before the run is abandoned
  localparam int QuietLimit = 2000;

  // clock and reset, reset held from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, all known from the start
  logic              window_width_we    = 1'b0;
  logic [TimeW-1:0]  window_width_wdata = '0;
  logic              s_axis_tvalid      = 1'b0;
  logic [23:0]       s_axis_tdata       = '0;  // hit_time[19:0], zero pad[23:20]
  logic [2:0]        s_axis_tuser       = '0;  // cmd[0], channel[2:1]
  logic              m_axis_tready      = 1'b0;

  // block outputs
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [63:0]       m_axis_tdata;   // accepted[0], window_valid[1], window_start[21:2],
                                     // window_end[41:22], slot_filled[42], slot_time[62:43]

  // predictor state: slots, window and the coincidence width
  logic [TimeW-1:0] slot_time_m [SLOTS];
  logic [SLOTS-1:0] slot_full_m = '0;
  logic [TimeW-1:0] win_lo      = '0;
  logic [TimeW-1:0] win_hi      = '0;
  logic             win_open    = 1'b0;
  logic [TimeW-1:0] width_m     = '0;

  // expected result beats, oldest first
  result_t pending_results [$];

  // flow control mix, in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // bookkeeping
  int n_sent         = 0;
  int n_kept         = 0;
  int n_refused      = 0;
  int n_clears       = 0;
  int n_width_writes = 0;
  int n_mismatch     = 0;
  int quiet_cycles   = 0;

  always #6 clk = ~clk;

  hit_time_coincidence_window_core dut (
    .clk                (clk),
    .rst                (rst),
    .window_width_we    (window_width_we),
    .window_width_wdata (window_width_wdata),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // forward distance from a to b around the time base, both below the range
  function automatic int wrap_gap(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    int d;
    d = int'(b) + Range - int'(a);
    if (d >= Range) d -= Range;
    return d;
  endfunction

  // apply one input beat to the model window and return the result it should produce
  function automatic result_t window_update(input cmd_t op, input logic [ChannelW-1:0] ch,
                                            input logic [TimeW-1:0] t);
    result_t r;
    logic    kept;
    logic    filled;
    int      slot;
    int      d1;
    int      d2;
    kept = 1'b0;
    slot = int'(ch);
    if (op == CMD_CLEAR) begin
      // slot times are left alone: they are only reported while the slot is full
      slot_full_m = '0;
      win_open    = 1'b0;
      win_lo      = '0;
      win_hi      = '0;
      n_clears++;
    end else begin
      if (slot < SLOTS && t < Range && !slot_full_m[slot]) begin
        if (!win_open) begin
          // first time since clear opens the window on itself
          win_lo   = t;
          win_hi   = t;
          win_open = 1'b1;
          kept     = 1'b1;
        end else begin
          d1 = wrap_gap(win_lo, t);
          d2 = wrap_gap(t, win_hi);
          if (d1 < int'(width_m)) begin
            // within width after the start: end follows unless t is the end itself
            if (d2 > 0) win_hi = t;
            kept = 1'b1;
          end else if (d2 < int'(width_m)) begin
            // within width before the end: start follows unless t is the start itself
            if (d1 > 0) win_lo = t;
            kept = 1'b1;
          end
        end
        if (kept) begin
          slot_time_m[slot] = t;
          slot_full_m[slot] = 1'b1;
        end
      end
      if (kept) n_kept++;
      else n_refused++;
    end
    filled = (op == CMD_STORE) && (slot < SLOTS) && slot_full_m[slot];
    r.accepted     = kept;
    r.window_valid = win_open;
    r.window_start = win_open ? win_lo : '0;
    r.window_end   = win_open ? win_hi : '0;
    r.slot_filled  = filled;
    r.slot_time    = filled ? slot_time_m[slot] : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one beat, with random idle cycles ahead of it, and record its expectation
  task automatic send_beat(input cmd_t op, input logic [ChannelW-1:0] ch,
                           input logic [TimeW-1:0] t);
    // valid drops only when a gap is taken, so back-to-back beats keep it high
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, t};
    s_axis_tuser  <= {ch, op};
    do @(posedge clk); while (!s_axis_tready);
    // taken at this edge: the model moves in step with the block
    pending_results.push_back(window_update(op, ch, t));
    n_sent++;
  endtask

  // stop offering beats and wait until every expected result has come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // write the coincidence width while the block is idle
  task automatic set_width(input logic [TimeW-1:0] w);
    window_width_we    <= 1'b1;
    window_width_wdata <= w;
    @(posedge clk);
    window_width_we <= 1'b0;
    width_m = w;
    n_width_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // receiver stalls at random according to the current mix
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endtask

  // every result beat is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending: tdata %h", m_axis_tdata);
        n_mismatch++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted",     want.accepted,     m_axis_tdata[0]);
        check_field("window_valid", want.window_valid, m_axis_tdata[1]);
        check_field("window_start", want.window_start, m_axis_tdata[21:2]);
        check_field("window_end",   want.window_end,   m_axis_tdata[41:22]);
        check_field("slot_filled",  want.slot_filled,  m_axis_tdata[42]);
        check_field("slot_time",    want.slot_time,    m_axis_tdata[62:43]);
      end
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // width still zero from reset: only the first time opens a window
  task automatic test_zero_width;
    send_beat(CMD_STORE, 2'd2, 20'd655360);   // at the wrap range, no window yet
    send_beat(CMD_STORE, 2'd0, 20'd0);        // opens the window
    send_beat(CMD_STORE, 2'd1, 20'd64);       // zero width refuses the rest
    send_beat(CMD_STORE, 2'd0, 20'd0);        // slot already full
    send_beat(CMD_CLEAR, 2'd3, 20'hFFFFF);    // clear ignores channel and time
  endtask

  // window that straddles the wrap point of the time base
  task automatic test_wrapped_window;
    drain();
    set_width(20'd3200);                      // 50 ns
    send_beat(CMD_STORE, 2'd2, 20'd655300);   // just below the wrap
    send_beat(CMD_STORE, 2'd3, 20'd1000);     // past the wrap, end moves forward
    send_beat(CMD_STORE, 2'd1, 20'd655200);   // before the start, start moves back
    send_beat(CMD_STORE, 2'd0, 20'hFFFFF);    // beyond the range
    send_beat(CMD_STORE, 2'd0, 20'd20000);    // outside both edges
    send_beat(CMD_STORE, 2'd0, 20'd655359);   // last time in range
    send_beat(CMD_CLEAR, 2'd0, 20'd0);
    send_beat(CMD_STORE, 2'd0, 20'd500);
    send_beat(CMD_STORE, 2'd1, 20'd500);      // equal to start and end, window stays
    send_beat(CMD_CLEAR, 2'd1, 20'd12345);
  endtask

  // width covering the whole range takes every time
  task automatic test_full_width;
    drain();
    set_width(20'd655360);
    send_beat(CMD_STORE, 2'd0, 20'd0);
    send_beat(CMD_STORE, 2'd1, 20'd655359);
    send_beat(CMD_STORE, 2'd2, 20'd327680);
    send_beat(CMD_STORE, 2'd3, 20'd12345);
    send_beat(CMD_CLEAR, 2'd2, 20'd7);
  endtask

  // mostly clear-then-fill sequences around a random base, with some noise
  task automatic random_bursts(input int n_items);
    int target;
    int base;
    int span;
    int t;
    int k;
    logic [ChannelW-1:0] ch;
    logic [SLOTS-1:0]    used;
    target = n_sent + n_items;
    while (n_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_beat(CMD_CLEAR, ChannelW'($urandom), TimeW'($urandom));
        // reach a little past the width so the edges get hit from both sides
        span = (width_m == 0) ? 64 : int'(width_m) + int'(width_m) / 4;
        base = int'($urandom_range(Range - 1));
        k    = int'($urandom_range(4, 1));
        used = '0;
        repeat (k) begin
          // now and then a channel repeats to hit the full-slot refusal
          do ch = ChannelW'($urandom); while (used[ch] && $urandom_range(9) != 0);
          used[ch] = 1'b1;
          t = (base + int'($urandom_range(2 * span)) - span) % Range;
          if (t < 0) t += Range;
          if ($urandom_range(19) == 0) t = int'(TimeW'($urandom));
          send_beat(CMD_STORE, ch, TimeW'(t));
        end
      end else begin
        send_beat(cmd_t'($urandom_range(9) == 0), ChannelW'($urandom), TimeW'($urandom));
      end
    end
  endtask

  // eight phases, each with its own width, cycling through four flow control mixes
  task automatic test_random_traffic;
    int widths [8] = '{3200, 64, 0, 655360, 1048575, 640, -1, 1};
    int mode;
    for (int p = 0; p < 8; p++) begin
      drain();
      set_width((widths[p] < 0) ? TimeW'($urandom_range(20000, 2)) : TimeW'(widths[p]));
      mode      = p % 4;
      idle_pct  = (mode == 1) ? 70 : (mode == 3) ? 17 : 0;
      stall_pct = (mode == 2) ? 70 : (mode == 3) ? 17 : 0;
      random_bursts(205);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_zero_width();
    test_wrapped_window();
    test_full_width();
    test_random_traffic();
    drain();
    // result is registered behind its input, so this wait catches any stray beat
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_mismatch++;
    end
    $display("%0d beats sent: %0d hit times kept, %0d refused, %0d clears",
             n_sent, n_kept, n_refused, n_clears);
    $display("%0d width settings from zero to full scale, under four flow control mixes",
             n_width_writes);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
